// ===== src/hgwa_pkg.sv =====
`timescale 1ns / 1ps
package hgwa_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_ETA        = 3'd0;
    localparam logic [2:0] REG_WIND_FROM  = 3'd1;
    localparam logic [2:0] REG_WIND_SPEED = 3'd2;
    localparam logic [2:0] REG_GRID_COLS  = 3'd3;
    localparam logic [2:0] REG_GRID_ROWS  = 3'd4;

    // line store entry: value, active, q, r
    localparam int unsigned ENTRY_W = 41;

    // ceil(2^27 / 10), exact floor division by ten for 23-bit numerators
    localparam logic [23:0] DIV10_RECIP = 24'd13421773;
    localparam logic [18:0] SPD_ONE     = 19'd65536;

    typedef struct packed {
        logic               mode;
        logic signed [15:0] cell_value;
        logic               cell_active;
        logic signed [11:0] axial_q;
        logic signed [11:0] axial_r;
    } t_cell;

    typedef struct packed {
        logic signed [31:0] advection;
        logic [15:0]        out_row;
        logic [7:0]         out_col;
        logic               last_of_field;
    } t_result;

    typedef struct packed {
        logic [2:0]  index;
        logic [15:0] wdata;
    } t_cfg;

    // max(0, cos(a))^2 in q1.15 for a = 0..90 degrees
    localparam logic [15:0] COS2_TAB [0:90] = '{
        16'd32768, 16'd32758, 16'd32728, 16'd32678, 16'd32609, 16'd32519, 16'd32410,
        16'd32281, 16'd32133, 16'd31966, 16'd31780, 16'd31575, 16'd31352, 16'd31110,
        16'd30850, 16'd30573, 16'd30278, 16'd29967, 16'd29639, 16'd29295, 16'd28935,
        16'd28560, 16'd28170, 16'd27765, 16'd27347, 16'd26915, 16'd26471, 16'd26014,
        16'd25546, 16'd25066, 16'd24576, 16'd24076, 16'd23566, 16'd23048, 16'd22522,
        16'd21988, 16'd21447, 16'd20900, 16'd20348, 16'd19790, 16'd19229, 16'd18664,
        16'd18097, 16'd17527, 16'd16956, 16'd16384, 16'd15812, 16'd15241, 16'd14671,
        16'd14104, 16'd13539, 16'd12978, 16'd12420, 16'd11868, 16'd11321, 16'd10780,
        16'd10246, 16'd9720,  16'd9202,  16'd8692,  16'd8192,  16'd7702,  16'd7222,
        16'd6754,  16'd6297,  16'd5853,  16'd5421,  16'd5003,  16'd4598,  16'd4208,
        16'd3833,  16'd3473,  16'd3129,  16'd2801,  16'd2490,  16'd2195,  16'd1918,
        16'd1658,  16'd1416,  16'd1193,  16'd988,   16'd802,   16'd635,   16'd487,
        16'd358,   16'd249,   16'd159,   16'd90,    16'd40,    16'd10,    16'd0
    };

    // exp(-d2) in q16 for d2 = 0..15
    localparam logic [16:0] DIST_TAB [0:15] = '{
        17'd65536, 17'd24109, 17'd8869, 17'd3263, 17'd1200, 17'd442, 17'd162, 17'd60,
        17'd22,    17'd8,     17'd3,    17'd1,    17'd0,    17'd0,   17'd0,   17'd0
    };

endpackage

// ===== src/hgwa_stream_if.sv =====
`timescale 1ns / 1ps
interface hgwa_stream_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/hex_grid_wind_advection_stencil.sv =====
`timescale 1ns / 1ps
// channel    dir  payload                                           accepted when
// i_cell     in   mode, cell_value, cell_active, axial_q, axial_r   valid & ready
// i_cfg      in   index, wdata                                      valid & ready
// o_result   out  advection, out_row, out_col, last_of_field        valid & ready
//
// one shared 41x25 multiplier under a one-hot sequencer does all the wide products
// a cell word takes accept and check states plus up to two results, with one more
// check between them; a result runs C0, C1, then per neighbor NRD alone if it lies outside
// the grid, NRD and NCHK if inactive or distant, NRD to ACC if used, then ETA, RND and
// OUT (an inactive center goes from C1 straight to OUT); a drain word runs one result
// synchronous active-low reset: pointers to zero, control registers to their defaults
// the line store is not cleared; entries are only read after being written
// i_cell is held off while a word is processed; a full output register stalls it
module hex_grid_wind_advection_stencil #(
    parameter int MAX_COLS = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hgwa_stream_if.sink   i_cell,
    hgwa_stream_if.sink   i_cfg,
    hgwa_stream_if.source o_result
);
    import hgwa_pkg::*;

    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CNW   = $clog2(MAX_COLS + 1);
    localparam int DEPTH = 3 * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);

    // neighbor directions
    localparam logic [2:0] DIR_E  = 3'd0;
    localparam logic [2:0] DIR_NE = 3'd1;
    localparam logic [2:0] DIR_NW = 3'd2;
    localparam logic [2:0] DIR_W  = 3'd3;
    localparam logic [2:0] DIR_SW = 3'd4;
    localparam logic [2:0] DIR_SE = 3'd5;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_CHECK = 13'b0000000000010,
        S_C0    = 13'b0000000000100,
        S_C1    = 13'b0000000001000,
        S_NRD   = 13'b0000000010000,
        S_NCHK  = 13'b0000000100000,
        S_M2    = 13'b0000001000000,
        S_M3    = 13'b0000010000000,
        S_M4    = 13'b0000100000000,
        S_ACC   = 13'b0001000000000,
        S_ETA   = 13'b0010000000000,
        S_RND   = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } t_state;

    // control registers
    t_state             r_state, n_state;
    logic signed [15:0] r_eta, n_eta;
    logic [8:0]         r_from, n_from;
    logic [9:0]         r_speed, n_speed;
    logic [8:0]         r_gcols, n_gcols;
    logic [15:0]        r_grows, n_grows;
    logic [CW-1:0]      r_in_col, n_in_col;
    logic [15:0]        r_in_row, n_in_row;
    logic [1:0]         r_in_slot, n_in_slot;
    logic [CW-1:0]      r_out_col, n_out_col;
    logic [15:0]        r_out_row, n_out_row;
    logic [1:0]         r_out_slot, n_out_slot;
    logic               r_cnt, n_cnt;
    logic               r_drain, n_drain;
    logic [2:0]         r_dir, n_dir;
    logic               r_ovalid, n_ovalid;

    // datapath registers
    logic [8:0]         r_ang, n_ang;
    logic [18:0]        r_spd, n_spd;
    logic signed [15:0] r_cv, n_cv;
    logic signed [11:0] r_cq, n_cq;
    logic signed [11:0] r_cr, n_cr;
    logic [18:0]        r_w1, n_w1;
    logic [16:0]        r_dist, n_dist;
    logic signed [16:0] r_diff, n_diff;
    logic [18:0]        r_w, n_w;
    logic signed [39:0] r_sum, n_sum;
    logic signed [65:0] r_prod;
    logic signed [31:0] r_res, n_res;
    t_result            r_odata, n_odata;

    // effective grid size
    logic [CNW-1:0] cols;
    logic [15:0]    rows;
    logic [16:0]    rows17;
    logic           in_done;

    always_comb begin
        if (r_gcols == '0) begin
            cols = CNW'(1);
        end else if (32'(r_gcols) > 32'(MAX_COLS)) begin
            cols = CNW'(MAX_COLS);
        end else begin
            cols = CNW'(r_gcols);
        end
    end

    assign rows    = (r_grows == '0) ? 16'd1 : r_grows;
    assign rows17  = {1'b0, rows};
    assign in_done = (r_in_row >= rows);

    // output pointer neighborhood
    logic [16:0]    out_row_p1;
    logic [CNW-1:0] out_col_p1;
    logic [CNW-1:0] in_col_p1;
    logic [CNW-1:0] col_next;
    logic           pending;
    logic           is_last;

    assign out_row_p1 = {1'b0, r_out_row} + 17'd1;
    assign out_col_p1 = CNW'(r_out_col) + CNW'(1);
    assign in_col_p1  = CNW'(r_in_col) + CNW'(1);
    assign col_next   = (out_col_p1 < cols) ? out_col_p1 : cols - CNW'(1);
    // the next result is not in the last row and every neighbor of it has arrived
    assign pending    = (out_row_p1 < rows17) &&
                        (({1'b0, r_in_row} > out_row_p1) ||
                         (({1'b0, r_in_row} == out_row_p1) && (CNW'(r_in_col) > col_next)));
    assign is_last    = (r_out_row == rows - 16'd1) && (CNW'(r_out_col) == cols - CNW'(1));

    // store addressing: slot is row mod 3
    function automatic logic [AW-1:0] f_addr(input logic [1:0] slot, input logic [CW-1:0] col);
        logic [AW-1:0] base;
        unique case (slot)
            2'd0:    base = '0;
            2'd1:    base = AW'(MAX_COLS);
            default: base = AW'(2 * MAX_COLS);
        endcase
        return base + AW'(col);
    endfunction

    // odd-r offset neighbor of the output cell
    logic signed [1:0] d_row, d_col;
    logic              odd_row;
    logic              nb_ok;
    logic [CW-1:0]     nb_col;
    logic [1:0]        nb_slot;

    assign odd_row = r_out_row[0];

    always_comb begin
        unique case (r_dir)
            DIR_E:   begin d_row = 2'sd0;  d_col = 2'sd1; end
            DIR_NE:  begin d_row = -2'sd1; d_col = odd_row ? 2'sd1 : 2'sd0; end
            DIR_NW:  begin d_row = -2'sd1; d_col = odd_row ? 2'sd0 : -2'sd1; end
            DIR_W:   begin d_row = 2'sd0;  d_col = -2'sd1; end
            DIR_SW:  begin d_row = 2'sd1;  d_col = odd_row ? 2'sd0 : -2'sd1; end
            DIR_SE:  begin d_row = 2'sd1;  d_col = odd_row ? 2'sd1 : 2'sd0; end
            default: begin d_row = 2'sd0;  d_col = 2'sd0; end
        endcase
    end

    always_comb begin
        nb_ok = 1'b1;
        if (d_row == -2'sd1 && r_out_row == '0) nb_ok = 1'b0;
        if (d_row == 2'sd1 && out_row_p1 >= rows17) nb_ok = 1'b0;
        if (d_col == -2'sd1 && r_out_col == '0) nb_ok = 1'b0;
        if (d_col == 2'sd1 && out_col_p1 >= cols) nb_ok = 1'b0;
        if (d_col == 2'sd1) begin
            nb_col = r_out_col + CW'(1);
        end else if (d_col == -2'sd1) begin
            nb_col = r_out_col - CW'(1);
        end else begin
            nb_col = r_out_col;
        end
        if (d_row == -2'sd1) begin
            nb_slot = (r_out_slot == 2'd0) ? 2'd2 : r_out_slot - 2'd1;
        end else if (d_row == 2'sd1) begin
            nb_slot = (r_out_slot == 2'd2) ? 2'd0 : r_out_slot + 2'd1;
        end else begin
            nb_slot = r_out_slot;
        end
    end

    // line store
    logic                cell_acc;
    logic                cfg_acc;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [AW-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic signed [15:0]  rd_val;
    logic                rd_act;
    logic signed [11:0]  rd_q, rd_r;

    assign cell_acc  = i_cell.valid && i_cell.ready;
    assign cfg_acc   = i_cfg.valid && i_cfg.ready;
    assign ram_we    = cell_acc && !i_cell.data.mode && !in_done;
    assign ram_waddr = f_addr(r_in_slot, r_in_col);
    assign ram_wdata = {i_cell.data.axial_r, i_cell.data.axial_q,
                        i_cell.data.cell_active, i_cell.data.cell_value};
    assign ram_raddr = (r_state == S_C0) ? f_addr(r_out_slot, r_out_col)
                                         : f_addr(nb_slot, nb_col);

    hgwa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_val = ram_rdata[15:0];
    assign rd_act = ram_rdata[16];
    assign rd_q   = ram_rdata[28:17];
    assign rd_r   = ram_rdata[40:29];

    // direction weight from the current wind angle
    logic [6:0]  cos_idx;
    logic [15:0] dirw;
    logic [8:0]  from_n;
    logic [9:0]  ang_sum;
    logic [8:0]  ang0;

    always_comb begin
        cos_idx = '0;
        dirw    = '0;
        if (r_ang <= 9'd90) begin
            cos_idx = r_ang[6:0];
            dirw    = COS2_TAB[cos_idx];
        end else if (r_ang >= 9'd270) begin
            cos_idx = 7'(9'd360 - r_ang);
            dirw    = COS2_TAB[cos_idx];
        end
    end

    assign from_n  = (r_from >= 9'd360) ? r_from - 9'd360 : r_from;
    assign ang_sum = {1'b0, from_n} + 10'd180;
    assign ang0    = (ang_sum >= 10'd360) ? 9'(ang_sum - 10'd360) : ang_sum[8:0];

    // neighbor distance: only |dq|,|dr| <= 3 can land inside the table
    logic signed [12:0] dq, dr;
    logic [1:0]         aq, ar;
    logic [4:0]         d2;
    logic               near;

    assign dq   = {rd_q[11], rd_q} - {r_cq[11], r_cq};
    assign dr   = {rd_r[11], rd_r} - {r_cr[11], r_cr};
    assign aq   = dq[12] ? 2'(-dq) : dq[1:0];
    assign ar   = dr[12] ? 2'(-dr) : dr[1:0];
    assign d2   = ({3'b0, aq} * {3'b0, aq}) + ({3'b0, ar} * {3'b0, ar});
    assign near = (dq >= -13'sd3) && (dq <= 13'sd3) && (dr >= -13'sd3) && (dr <= 13'sd3)
                  && (d2 < 5'd16);

    // shared multiplier
    logic signed [40:0] mul_a;
    logic signed [24:0] mul_b;
    logic [21:0]        spd_num;

    assign spd_num = {r_speed, 12'd0} + 22'd5;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_C0: begin
                mul_a = $signed({19'd0, spd_num});
                mul_b = $signed({1'b0, DIV10_RECIP});
            end
            S_NRD: begin
                mul_a = $signed({22'd0, r_spd});
                mul_b = $signed({9'd0, dirw});
            end
            S_M2: begin
                mul_a = $signed({22'd0, r_w1});
                mul_b = $signed({8'd0, r_dist});
            end
            S_M4: begin
                mul_a = $signed({22'd0, r_w});
                mul_b = {{8{r_diff[16]}}, r_diff};
            end
            S_ETA: begin
                mul_a = {r_sum[39], r_sum};
                mul_b = {{9{r_eta[15]}}, r_eta};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // rounding helpers
    logic signed [65:0] w1_full, w_full, rnd_bias, rnd;

    assign w1_full  = r_prod + 66'sd16384;
    assign w_full   = r_prod + 66'sd32768;
    // ties away from zero
    assign rnd_bias = r_prod[65] ? 66'sd524287 : 66'sd524288;
    assign rnd      = (r_prod + rnd_bias) >>> 20;

    logic out_free;
    assign out_free = !r_ovalid || o_result.ready;

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_eta      = r_eta;
        n_from     = r_from;
        n_speed    = r_speed;
        n_gcols    = r_gcols;
        n_grows    = r_grows;
        n_in_col   = r_in_col;
        n_in_row   = r_in_row;
        n_in_slot  = r_in_slot;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        n_out_slot = r_out_slot;
        n_cnt      = r_cnt;
        n_drain    = r_drain;
        n_dir      = r_dir;
        n_ovalid   = r_ovalid;
        n_ang      = r_ang;
        n_spd      = r_spd;
        n_cv       = r_cv;
        n_cq       = r_cq;
        n_cr       = r_cr;
        n_w1       = r_w1;
        n_dist     = r_dist;
        n_diff     = r_diff;
        n_w        = r_w;
        n_sum      = r_sum;
        n_res      = r_res;
        n_odata    = r_odata;

        if (r_ovalid && o_result.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (cell_acc) begin
                    if (i_cell.data.mode) begin
                        if (in_done && r_out_row < rows) begin
                            n_drain = 1'b1;
                            n_state = S_C0;
                        end
                    end else if (!in_done) begin
                        if (in_col_p1 >= cols) begin
                            n_in_col  = '0;
                            n_in_row  = r_in_row + 16'd1;
                            n_in_slot = (r_in_slot == 2'd2) ? 2'd0 : r_in_slot + 2'd1;
                        end else begin
                            n_in_col = CW'(in_col_p1);
                        end
                        n_cnt   = 1'b0;
                        n_drain = 1'b0;
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                n_state = pending ? S_C0 : S_IDLE;
            end
            S_C0: begin
                n_ang   = ang0;
                n_dir   = DIR_E;
                n_sum   = '0;
                n_state = S_C1;
            end
            S_C1: begin
                n_spd = r_prod[45:27] + SPD_ONE;
                n_cv  = rd_val;
                n_cq  = rd_q;
                n_cr  = rd_r;
                if (!rd_act) begin
                    // inactive center gives zero
                    n_res   = '0;
                    n_state = S_OUT;
                end else begin
                    n_state = S_NRD;
                end
            end
            S_NRD: begin
                if (nb_ok) begin
                    n_state = S_NCHK;
                end else begin
                    n_dir   = r_dir + 3'd1;
                    n_ang   = (r_ang >= 9'd60) ? r_ang - 9'd60 : r_ang + 9'd300;
                    n_state = (r_dir == DIR_SE) ? S_ETA : S_NRD;
                end
            end
            S_NCHK: begin
                n_w1 = w1_full[33:15];
                if (rd_act && near) begin
                    n_dist  = DIST_TAB[d2[3:0]];
                    n_diff  = {rd_val[15], rd_val} - {r_cv[15], r_cv};
                    n_state = S_M2;
                end else begin
                    n_dir   = r_dir + 3'd1;
                    n_ang   = (r_ang >= 9'd60) ? r_ang - 9'd60 : r_ang + 9'd300;
                    n_state = (r_dir == DIR_SE) ? S_ETA : S_NRD;
                end
            end
            S_M2: begin
                n_state = S_M3;
            end
            S_M3: begin
                n_w     = w_full[34:16];
                n_state = S_M4;
            end
            S_M4: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                n_sum   = r_sum + r_prod[39:0];
                n_dir   = r_dir + 3'd1;
                n_ang   = (r_ang >= 9'd60) ? r_ang - 9'd60 : r_ang + 9'd300;
                n_state = (r_dir == DIR_SE) ? S_ETA : S_NRD;
            end
            S_ETA: begin
                n_state = S_RND;
            end
            S_RND: begin
                if (rnd > 66'sd2147483647) begin
                    n_res = 32'sh7fffffff;
                end else if (rnd < -66'sd2147483648) begin
                    n_res = 32'sh80000000;
                end else begin
                    n_res = rnd[31:0];
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_ovalid                = 1'b1;
                    n_odata.advection       = r_res;
                    n_odata.out_row         = r_out_row;
                    n_odata.out_col         = 8'(32'(r_out_col));
                    n_odata.last_of_field   = is_last;
                    if (is_last) begin
                        n_in_col   = '0;
                        n_in_row   = '0;
                        n_in_slot  = '0;
                        n_out_col  = '0;
                        n_out_row  = '0;
                        n_out_slot = '0;
                    end else if (out_col_p1 >= cols) begin
                        n_out_col  = '0;
                        n_out_row  = r_out_row + 16'd1;
                        n_out_slot = (r_out_slot == 2'd2) ? 2'd0 : r_out_slot + 2'd1;
                    end else begin
                        n_out_col = CW'(out_col_p1);
                    end
                    if (r_drain || r_cnt) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cnt   = 1'b1;
                        n_state = S_CHECK;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // register writes; a grid size write restarts the frame
        if (cfg_acc) begin
            unique case (i_cfg.data.index)
                REG_ETA:        n_eta   = i_cfg.data.wdata;
                REG_WIND_FROM:  n_from  = i_cfg.data.wdata[8:0];
                REG_WIND_SPEED: n_speed = i_cfg.data.wdata[9:0];
                REG_GRID_COLS:  n_gcols = i_cfg.data.wdata[8:0];
                REG_GRID_ROWS:  n_grows = i_cfg.data.wdata;
                default:        n_eta   = r_eta;
            endcase
            if (i_cfg.data.index == REG_GRID_COLS || i_cfg.data.index == REG_GRID_ROWS) begin
                n_in_col   = '0;
                n_in_row   = '0;
                n_in_slot  = '0;
                n_out_col  = '0;
                n_out_row  = '0;
                n_out_slot = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_eta      <= 16'sd2048;
            r_from     <= 9'd270;
            r_speed    <= 10'd48;
            r_gcols    <= 9'd256;
            r_grows    <= 16'd256;
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_in_slot  <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_out_slot <= '0;
            r_cnt      <= 1'b0;
            r_drain    <= 1'b0;
            r_dir      <= DIR_E;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_eta      <= n_eta;
            r_from     <= n_from;
            r_speed    <= n_speed;
            r_gcols    <= n_gcols;
            r_grows    <= n_grows;
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_in_slot  <= n_in_slot;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_out_slot <= n_out_slot;
            r_cnt      <= n_cnt;
            r_drain    <= n_drain;
            r_dir      <= n_dir;
            r_ovalid   <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ang   <= n_ang;
        r_spd   <= n_spd;
        r_cv    <= n_cv;
        r_cq    <= n_cq;
        r_cr    <= n_cr;
        r_w1    <= n_w1;
        r_dist  <= n_dist;
        r_diff  <= n_diff;
        r_w     <= n_w;
        r_sum   <= n_sum;
        r_res   <= n_res;
        r_odata <= n_odata;
        r_prod  <= mul_a * mul_b;
    end

    assign i_cell.ready   = (r_state == S_IDLE);
    assign i_cfg.ready    = 1'b1;
    assign o_result.valid = r_ovalid;
    assign o_result.data  = r_odata;
endmodule

// ===== src/hgwa_ram.sv =====
`timescale 1ns / 1ps
module hgwa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import hgwa_pkg::*;

    localparam int MAX_COLS    = 256;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int ITEM_BUDGET = 1600;
    localparam int SETTLE      = 200;   // worst cell plus two results, with margin

    // -------------------------------------------------------------------------
    // stencil predictor and queue of pending advection results
    // -------------------------------------------------------------------------
    class advection_scoreboard;
        logic [40:0]  line_store [0:3*MAX_COLS-1];
        int unsigned  in_col, in_row, out_col, out_row;
        logic [15:0]  eta;
        int unsigned  from_deg, speed, cols_reg, rows_reg;
        t_result      pending_results [$];
        int           errors;

        function void reset_state();
            eta      = 16'd2048;
            from_deg = 270;
            speed    = 48;
            cols_reg = 256;
            rows_reg = 256;
            restart();
        endfunction

        function void restart();
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
        endfunction

        function int unsigned cols_eff();
            if (cols_reg == 0) return 1;
            if (cols_reg > MAX_COLS) return MAX_COLS;
            return cols_reg;
        endfunction

        function int unsigned rows_eff();
            return (rows_reg == 0) ? 1 : rows_reg;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] v);
            case (idx)
                REG_ETA:        eta = v;
                REG_WIND_FROM:  from_deg = v[8:0];
                REG_WIND_SPEED: speed = v[9:0];
                REG_GRID_COLS: begin
                    cols_reg = v[8:0];
                    restart();
                end
                REG_GRID_ROWS: begin
                    rows_reg = v;
                    restart();
                end
                default: ;
            endcase
        endfunction

        function longint cos2_of(int dir);
            int unsigned f, a;
            f = from_deg;
            if (f >= 360) f -= 360;
            a = f + 180 + 360 - 60 * dir;
            while (a >= 360) a -= 360;
            if (a <= 90) return COS2_TAB[a];
            if (a >= 270) return COS2_TAB[360 - a];
            return 0;
        endfunction

        function logic signed [31:0] advection_at(int unsigned r, int unsigned c);
            int          dc_even [6] = '{1, 0, -1, -1, -1, 0};
            int          dc_odd  [6] = '{1, 1, 0, -1, 0, 1};
            int          dr_tab  [6] = '{0, -1, -1, 0, 1, 1};
            logic [40:0] ce, ne;
            longint      cv, cq, cr, nv, dq, dr, d2, nr, nc, spd, w1, w, sum, p, mag;
            ce  = line_store[(r % 3) * MAX_COLS + (c % MAX_COLS)];
            if (!ce[16]) return 0;
            cv  = $signed(ce[15:0]);
            cq  = $signed(ce[28:17]);
            cr  = $signed(ce[40:29]);
            spd = 65536 + (longint'(speed) * 4096 + 5) / 10;
            sum = 0;
            for (int d = 0; d < 6; d++) begin
                nr = longint'(r) + dr_tab[d];
                nc = longint'(c) + (r[0] ? dc_odd[d] : dc_even[d]);
                if (nr < 0 || nc < 0 || nr >= rows_eff() || nc >= cols_eff()) continue;
                ne = line_store[(nr % 3) * MAX_COLS + (nc % MAX_COLS)];
                if (!ne[16]) continue;
                dq = longint'($signed(ne[28:17])) - cq;
                dr = longint'($signed(ne[40:29])) - cr;
                d2 = dq * dq + dr * dr;
                if (d2 >= 16) continue;
                nv  = $signed(ne[15:0]);
                w1  = (cos2_of(d) * spd + 16384) >>> 15;
                w   = (w1 * longint'(DIST_TAB[d2]) + 32768) >>> 16;
                sum += w * (nv - cv);
            end
            // round half away from zero, then clamp to 32 bits
            p   = sum * longint'($signed(eta));
            mag = (p < 0) ? -p : p;
            mag = (mag + (longint'(1) << 19)) >>> 20;
            p   = (p < 0) ? -mag : mag;
            if (p > 64'sh7FFF_FFFF) p = 64'sh7FFF_FFFF;
            if (p < -64'sh8000_0000) p = -64'sh8000_0000;
            return p[31:0];
        endfunction

        // next output cell is not in the last row and has all its neighbors in the store
        function bit next_ready();
            int unsigned cn;
            if (out_row + 1 >= rows_eff()) return 0;
            cn = (out_col + 1 < cols_eff()) ? out_col + 1 : cols_eff() - 1;
            return in_row > out_row + 1 || (in_row == out_row + 1 && in_col > cn);
        endfunction

        function void produce();
            t_result res;
            bit      last;
            last              = (out_row == rows_eff() - 1) && (out_col == cols_eff() - 1);
            res.advection     = advection_at(out_row, out_col);
            res.out_row       = out_row[15:0];
            res.out_col       = out_col[7:0];
            res.last_of_field = last;
            pending_results.push_back(res);
            if (last) begin
                restart();
            end else if (++out_col >= cols_eff()) begin
                out_col = 0;
                out_row++;
            end
        endfunction

        function void note_cell(t_cell x);
            int n;
            n = 0;
            if (x.mode) begin
                if (in_row >= rows_eff() && out_row < rows_eff()) produce();
                return;
            end
            if (in_row >= rows_eff()) return;    // grid complete, cell ignored
            line_store[(in_row % 3) * MAX_COLS + (in_col % MAX_COLS)] =
                {x.axial_r, x.axial_q, x.cell_active, x.cell_value};
            if (++in_col >= cols_eff()) begin
                in_col = 0;
                in_row++;
            end
            while (n < 2 && next_ready()) begin
                produce();
                n++;
            end
        endfunction

        function void check(t_result got);
            t_result exp_res;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word %p", got);
                return;
            end
            exp_res = pending_results.pop_front();
            if (got.advection !== exp_res.advection || got.out_row !== exp_res.out_row ||
                got.out_col !== exp_res.out_col ||
                got.last_of_field !== exp_res.last_of_field) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: expected adv %0d row %0d col %0d last %0b,",
                              " got adv %0d row %0d col %0d last %0b"},
                        exp_res.advection, exp_res.out_row, exp_res.out_col,
                        exp_res.last_of_field, got.advection, got.out_row, got.out_col,
                        got.last_of_field);
            end
        endfunction
    endclass

    // -------------------------------------------------------------------------
    // clock, reset, channels
    // -------------------------------------------------------------------------
    logic i_clk;
    logic i_rst_n;

    hgwa_stream_if #(.t_payload(t_cell))   cell_if ();
    hgwa_stream_if #(.t_payload(t_cfg))    cfg_if ();
    hgwa_stream_if #(.t_payload(t_result)) res_if ();

    hex_grid_wind_advection_stencil #(.MAX_COLS(MAX_COLS)) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cell   (cell_if),
        .i_cfg    (cfg_if),
        .o_result (res_if)
    );

    advection_scoreboard sb;
    int unsigned cycles;
    int          items_sent;
    bit          calm;          // no random idling on either side this phase
    bit          long_hold;     // receiver backs off for a long stretch
    int          hold_left;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // result receiver: stall draw per word, plus one long back-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (long_hold) begin
            long_hold    = 1'b0;
            hold_left    = 400;
            res_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left    = hold_left - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // result monitor, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            sb.check(res_if.data);
            hold_left = calm ? 0 : $urandom_range(0, 5);
        end
    end

    // -------------------------------------------------------------------------
    // drivers
    // -------------------------------------------------------------------------
    // called right after an acceptance edge or from idle; valid is only lowered
    // when a gap follows, so it never toggles twice in one step
    task automatic send_word(t_cell x);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        @(negedge i_clk);
        if (gap > 0) begin
            cell_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cell_if.valid <= 1'b1;
        cell_if.data  <= x;
        do @(posedge i_clk); while (!cell_if.ready);
        sb.note_cell(x);
        items_sent++;
    endtask

    task automatic stop_words();
        @(negedge i_clk);
        cell_if.valid <= 1'b0;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] v);
        t_cfg c;
        c.index = idx;
        c.wdata = v;
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= c;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.write_reg(idx, v);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // all results in, then let a trailing cell word finish inside the block
    task automatic wait_idle();
        while (sb.pending_results.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic t_cell drain_word();
        t_cell x;
        x      = t_cell'(42'({$urandom, $urandom}));
        x.mode = 1'b1;
        return x;
    endfunction

    // grid cell with coordinates close to its neighbors so the distance term bites
    function automatic t_cell grid_word(int r, int c);
        t_cell x;
        int    pick;
        x.mode        = 1'b0;
        pick          = $urandom_range(0, 9);
        x.cell_value  = (pick == 0) ? 16'sh7FFF : (pick == 1) ? 16'sh8000 : 16'($urandom);
        x.cell_active = ($urandom_range(0, 4) != 0);
        if ($urandom_range(0, 19) == 0) begin
            x.axial_q = 12'($urandom);
            x.axial_r = 12'($urandom);
        end else begin
            x.axial_q = 12'(c + (($urandom_range(0, 6) == 0) ? $urandom_range(0, 2) - 1 : 0));
            x.axial_r = 12'(r + (($urandom_range(0, 6) == 0) ? $urandom_range(0, 2) - 1 : 0));
        end
        return x;
    endfunction

    // one full raster frame with some stray drains, then the last row drained
    task automatic run_frame(int cols, int rows);
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
                if ($urandom_range(0, 9) == 0) send_word(drain_word());
                send_word(grid_word(r, c));
            end
        end
        // a cell after completion is ignored
        if ($urandom_range(0, 3) == 0) send_word(grid_word(0, 0));
        for (int i = 0; i < cols; i++) send_word(drain_word());
        stop_words();
    endtask

    // -------------------------------------------------------------------------
    // stimulus
    // -------------------------------------------------------------------------
    initial begin
        int    cols, rows, pick, phase;
        t_cell x;
        sb              = new();
        cycles          = 0;
        items_sent      = 0;
        calm            = 1'b0;
        long_hold       = 1'b0;
        hold_left       = 0;
        cell_if.valid   = 1'b0;
        cell_if.data    = '0;
        cfg_if.valid    = 1'b0;
        cfg_if.data     = '0;
        i_rst_n         = 1'b0;
        sb.reset_state();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: drain with nothing ready, under the reset grid size
        send_word(drain_word());
        send_word(grid_word(0, 0));
        send_word(drain_word());
        stop_words();
        wait_idle();

        // saturation: top gain and speed, wind along a neighbor, extreme values
        write_reg(REG_ETA, 16'h7FFF);
        write_reg(REG_WIND_SPEED, 16'd1023);
        write_reg(REG_WIND_FROM, 16'd0);
        write_reg(REG_GRID_COLS, 16'd3);
        write_reg(REG_GRID_ROWS, 16'd2);
        for (int i = 0; i < 6; i++) begin
            x.mode        = 1'b0;
            x.cell_value  = i[0] ? 16'sh8000 : 16'sh7FFF;
            x.cell_active = 1'b1;
            x.axial_q     = '0;
            x.axial_r     = '0;
            send_word(x);
        end
        send_word(grid_word(0, 0));
        for (int i = 0; i < 4; i++) send_word(drain_word());
        stop_words();
        wait_idle();

        // grid sizes of zero act as one; lowest gain, wind from the far end
        write_reg(REG_ETA, 16'h8000);
        write_reg(REG_WIND_FROM, 16'd359);
        write_reg(REG_WIND_SPEED, 16'd0);
        write_reg(REG_GRID_COLS, 16'd0);
        write_reg(REG_GRID_ROWS, 16'd0);
        run_frame(1, 1);
        wait_idle();

        // random phases
        phase = 0;
        while (items_sent < ITEM_BUDGET) begin
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1)) write_reg(REG_ETA, 16'($urandom));
            if ($urandom_range(0, 1)) write_reg(REG_WIND_FROM, 16'($urandom_range(0, 511)));
            if ($urandom_range(0, 1)) write_reg(REG_WIND_SPEED, 16'($urandom_range(0, 1023)));
            pick = $urandom_range(0, 19);
            if (phase == 7)      cols = 256 + $urandom_range(0, 1) * $urandom_range(1, 255);
            else if (pick == 0)  cols = 0;
            else if (pick < 4)   cols = $urandom_range(9, 40);
            else                 cols = $urandom_range(1, 8);
            pick = $urandom_range(0, 19);
            if (pick == 0)       rows = 0;
            else if (pick == 1)  rows = 65535;
            else                 rows = (cols > 40) ? $urandom_range(1, 3) : $urandom_range(1, 6);
            write_reg(REG_GRID_COLS, 16'(cols));
            write_reg(REG_GRID_ROWS, 16'(rows));
            if (phase == 4) long_hold = 1'b1;
            cols = (cols == 0) ? 1 : (cols > MAX_COLS) ? MAX_COLS : cols;
            rows = (rows == 0) ? 1 : rows;
            if (rows == 65535 || $urandom_range(0, 6) == 0) begin
                // broken frame: a partial stream with noise, cut off by the next size write
                pick = $urandom_range(1, 40);
                for (int i = 0; i < pick; i++) begin
                    if ($urandom_range(0, 4) == 0) send_word(drain_word());
                    else send_word(grid_word(i / cols, i % cols));
                end
                stop_words();
            end else begin
                run_frame(cols, rows);
            end
            wait_idle();
            phase++;
        end

        while (sb.pending_results.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule
